FILE: hdl/tsep_pkg.sv
// ----------------------------------------------------------------------------
// tsep_pkg: shared types and constants for the timestamp-to-epoch unit
// Character codes, kept-length codes, stage payload types and the small
// calendar helpers used by the parser and the day-count pipeline.
// ----------------------------------------------------------------------------
package tsep_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Z     = 8'h5A;

	localparam logic [1:0] FRAC_NONE = 2'd0;
	localparam logic [1:0] FRAC_DROP = 2'd1;
	localparam logic [1:0] FRAC_DONE = 2'd2;

	localparam logic [4:0] POS_SUFFIX = 5'd19;
	localparam logic [4:0] POS_MAX    = 5'd31;
	localparam logic [4:0] LEN_BODY   = 5'd19;
	localparam logic [4:0] LEN_ZULU   = 5'd20;
	localparam logic [4:0] LEN_HH     = 5'd22;
	localparam logic [4:0] LEN_HHMM   = 5'd25;

	localparam logic [6:0] MAX_MONTH  = 7'd12;
	localparam logic [6:0] MAX_DAY    = 7'd31;
	localparam logic [6:0] MAX_HOUR   = 7'd23;
	localparam logic [6:0] MAX_MINUTE = 7'd59;
	localparam logic [6:0] MAX_SECOND = 7'd60;
	localparam logic [6:0] MAX_ZONE_H = 7'd14;
	localparam logic [6:0] MAX_ZONE_M = 7'd59;

	localparam int EPOCH_W = 39;
	localparam int DAYS_W  = 24;
	localparam int TOD_W   = 19;

	localparam logic [10:0] ERA_RECIP      = 11'd1311;
	localparam logic [23:0] DAYS_PER_ERA   = 24'd146097;
	localparam logic [23:0] DAYS_TO_EPOCH  = 24'd719468;
	localparam logic [23:0] DAYS_PER_YEAR  = 24'd365;
	localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN   = 17'd60;
	localparam logic [40:0] SECS_PER_DAY   = 41'd86400;

	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        off_neg;
		logic [4:0]  off_h;
		logic [5:0]  off_m;
	} date_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DAYS_W-1:0] days;
		logic signed [TOD_W-1:0]  tod;
	} days_t;

	function automatic logic [6:0] two_digit(input logic [3:0] tens, input logic [3:0] ones);
		two_digit = {3'b000, tens} * 7'd10 + {3'b000, ones};
	endfunction

	// Day of the March-based year on which each month starts
	function automatic logic [8:0] month_start(input logic [3:0] m);
		case (m)
			4'd3:    month_start = 9'd0;
			4'd4:    month_start = 9'd31;
			4'd5:    month_start = 9'd61;
			4'd6:    month_start = 9'd92;
			4'd7:    month_start = 9'd122;
			4'd8:    month_start = 9'd153;
			4'd9:    month_start = 9'd184;
			4'd10:   month_start = 9'd214;
			4'd11:   month_start = 9'd245;
			4'd12:   month_start = 9'd275;
			4'd1:    month_start = 9'd306;
			4'd2:    month_start = 9'd337;
			default: month_start = 9'd0;
		endcase
	endfunction

endpackage

FILE: hdl/tsep_if.sv
// ----------------------------------------------------------------------------
// tsep_if: valid/ready channels of the timestamp-to-epoch unit
// Text channel carries one character beat; result channel one epoch result.
// ----------------------------------------------------------------------------
interface tsep_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       has_char;
	logic       last;

	modport source (output valid, output character, output has_char, output last, input ready);
	modport sink (input valid, input character, input has_char, input last, output ready);
endinterface

interface tsep_result_if;
	logic                               valid;
	logic                               ready;
	logic                               ok;
	logic signed [tsep_pkg::EPOCH_W-1:0] epoch_seconds;

	modport source (output valid, output ok, output epoch_seconds, input ready);
	modport sink (input valid, input ok, input epoch_seconds, output ready);
endinterface

FILE: hdl/tsep_parse.sv
// ----------------------------------------------------------------------------
// tsep_parse: character parser
// Checks each kept character at its fixed position, gathers the date, time
// and zone fields, drops the fraction, and on the last beat registers the
// finished fields into the first pipeline stage.
// ----------------------------------------------------------------------------
module tsep_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           character,
	input  logic                 has_char,
	input  logic                 last,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output tsep_pkg::date_t      dn_data
);

	logic [4:0]  pos_q, pos_n;
	logic [1:0]  frac_q, frac_n;
	logic [13:0] year_q, year_n;
	logic [3:0]  month_q, month_n;
	logic [4:0]  day_q, day_n;
	logic [4:0]  hour_q, hour_n;
	logic [5:0]  minute_q, minute_n;
	logic [5:0]  second_q, second_n;
	logic        neg_q, neg_n;
	logic [4:0]  zh_q, zh_n;
	logic [5:0]  zm_q, zm_n;
	logic        err_q, err_n;
	logic        zulu_q, zulu_n;

	logic            s1_v_q;
	tsep_pkg::date_t s1_q;
	tsep_pkg::date_t fin;

	logic       acc;
	logic       keep;
	logic       dig;
	logic       is_sfx;
	logic [7:0] dfull;
	logic [3:0] d;
	logic [6:0] v;
	logic       len_ok;

	assign in_ready = !s1_v_q || dn_ready;
	assign acc      = in_valid && in_ready;
	assign dn_valid = s1_v_q;
	assign dn_data  = s1_q;

	always_comb begin
		pos_n    = pos_q;
		frac_n   = frac_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		neg_n    = neg_q;
		zh_n     = zh_q;
		zm_n     = zm_q;
		err_n    = err_q;
		zulu_n   = zulu_q;
		keep     = 1'b0;
		dfull    = character - tsep_pkg::CH_ZERO;
		d        = dfull[3:0];
		dig      = character inside {[tsep_pkg::CH_ZERO:tsep_pkg::CH_NINE]};
		is_sfx   = character inside {tsep_pkg::CH_PLUS, tsep_pkg::CH_DASH, tsep_pkg::CH_Z};
		v        = 7'd0;

		if (has_char) begin
			if (frac_q == tsep_pkg::FRAC_NONE && character == tsep_pkg::CH_DOT) begin
				frac_n = tsep_pkg::FRAC_DROP;
			end else if (frac_q == tsep_pkg::FRAC_DROP) begin
				if (is_sfx) begin
					frac_n = tsep_pkg::FRAC_DONE;
					keep   = 1'b1;
				end
			end else begin
				keep = 1'b1;
			end
		end

		if (keep) begin
			if (pos_q != tsep_pkg::POS_MAX) begin
				pos_n = pos_q + 5'd1;
			end
			if (!err_q) begin
				case (pos_q)
					5'd4, 5'd7: begin
						if (character != tsep_pkg::CH_DASH) err_n = 1'b1;
					end
					5'd10: begin
						if (character != tsep_pkg::CH_SPACE) err_n = 1'b1;
					end
					5'd13, 5'd16: begin
						if (character != tsep_pkg::CH_COLON) err_n = 1'b1;
					end
					tsep_pkg::POS_SUFFIX: begin
						if (character == tsep_pkg::CH_Z) begin
							zulu_n = 1'b1;
						end else if (character == tsep_pkg::CH_PLUS) begin
							neg_n = 1'b0;
						end else if (character == tsep_pkg::CH_DASH) begin
							neg_n = 1'b1;
						end else begin
							err_n = 1'b1;
						end
					end
					5'd22: begin
						if (zulu_q || character != tsep_pkg::CH_COLON) err_n = 1'b1;
					end
					5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12,
					5'd14, 5'd15, 5'd17, 5'd18, 5'd20, 5'd21, 5'd23, 5'd24: begin
						if (!dig || (zulu_q && pos_q > tsep_pkg::POS_SUFFIX)) begin
							err_n = 1'b1;
						end else begin
							case (pos_q)
								5'd0, 5'd1, 5'd2, 5'd3: begin
									year_n = year_q * 14'd10 + {10'd0, d};
								end
								5'd5:  month_n = d;
								5'd6: begin
									v = tsep_pkg::two_digit(month_q, d);
									if (v < 7'd1 || v > tsep_pkg::MAX_MONTH) err_n = 1'b1;
									else month_n = v[3:0];
								end
								5'd8:  day_n = {1'b0, d};
								5'd9: begin
									v = tsep_pkg::two_digit(day_q[3:0], d);
									if (v < 7'd1 || v > tsep_pkg::MAX_DAY) err_n = 1'b1;
									else day_n = v[4:0];
								end
								5'd11: hour_n = {1'b0, d};
								5'd12: begin
									v = tsep_pkg::two_digit(hour_q[3:0], d);
									if (v > tsep_pkg::MAX_HOUR) err_n = 1'b1;
									else hour_n = v[4:0];
								end
								5'd14: minute_n = {2'b00, d};
								5'd15: begin
									v = tsep_pkg::two_digit(minute_q[3:0], d);
									if (v > tsep_pkg::MAX_MINUTE) err_n = 1'b1;
									else minute_n = v[5:0];
								end
								5'd17: second_n = {2'b00, d};
								5'd18: begin
									v = tsep_pkg::two_digit(second_q[3:0], d);
									if (v > tsep_pkg::MAX_SECOND) err_n = 1'b1;
									else second_n = v[5:0];
								end
								5'd20: zh_n = {1'b0, d};
								5'd21: begin
									v = tsep_pkg::two_digit(zh_q[3:0], d);
									if (v > tsep_pkg::MAX_ZONE_H) err_n = 1'b1;
									else zh_n = v[4:0];
								end
								5'd23: zm_n = {2'b00, d};
								default: begin
									v = tsep_pkg::two_digit(zm_q[3:0], d);
									if (v > tsep_pkg::MAX_ZONE_M) err_n = 1'b1;
									else zm_n = v[5:0];
								end
							endcase
						end
					end
					default: err_n = 1'b1;
				endcase
			end
		end
	end

	always_comb begin
		case (pos_n)
			tsep_pkg::LEN_BODY, tsep_pkg::LEN_HH, tsep_pkg::LEN_HHMM: len_ok = 1'b1;
			tsep_pkg::LEN_ZULU: len_ok = zulu_n;
			default: len_ok = 1'b0;
		endcase
		fin.ok      = len_ok && !err_n;
		fin.year    = year_n;
		fin.month   = month_n;
		fin.day     = day_n;
		fin.hour    = hour_n;
		fin.minute  = minute_n;
		fin.second  = second_n;
		fin.off_neg = neg_n;
		fin.off_h   = (pos_n == tsep_pkg::LEN_HH || pos_n == tsep_pkg::LEN_HHMM) ? zh_n : 5'd0;
		fin.off_m   = (pos_n == tsep_pkg::LEN_HHMM) ? zm_n : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			frac_q   <= tsep_pkg::FRAC_NONE;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			neg_q    <= 1'b0;
			zh_q     <= '0;
			zm_q     <= '0;
			err_q    <= 1'b0;
			zulu_q   <= 1'b0;
		end else if (acc) begin
			if (last) begin
				pos_q    <= '0;
				frac_q   <= tsep_pkg::FRAC_NONE;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				neg_q    <= 1'b0;
				zh_q     <= '0;
				zm_q     <= '0;
				err_q    <= 1'b0;
				zulu_q   <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				frac_q   <= frac_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				neg_q    <= neg_n;
				zh_q     <= zh_n;
				zm_q     <= zm_n;
				err_q    <= err_n;
				zulu_q   <= zulu_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc && last) begin
			s1_v_q <= 1'b1;
		end else if (dn_ready) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last) begin
			s1_q <= fin;
		end
	end

endmodule

FILE: hdl/tsep_days.sv
// ----------------------------------------------------------------------------
// tsep_days: civil date to day count pipeline
// Three stages: era and time of day, year of era, then the day count since
// 1970-01-01. Each stage holds while the next one is full and cannot pass its data on.
// ----------------------------------------------------------------------------
module tsep_days (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  tsep_pkg::date_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output tsep_pkg::days_t dn_data
);

	logic ld2, ld3, ld4;
	logic v2_q, v3_q, v4_q;

	// stage 2
	logic                                ok_s2;
	logic                                yneg_s2;
	logic [13:0]                         yadj_s2;
	logic [4:0]                          era_s2;
	logic [8:0]                          doyd_s2;
	logic signed [tsep_pkg::TOD_W-1:0]   tod_s2;

	// stage 3
	logic                                ok_s3;
	logic [8:0]                          yoe_s3;
	logic signed [tsep_pkg::DAYS_W-1:0]  erad_s3;
	logic [8:0]                          doyd_s3;
	logic signed [tsep_pkg::TOD_W-1:0]   tod_s3;

	// stage 4
	tsep_pkg::days_t                     res_s4;

	logic        adj;
	logic        yneg;
	logic [13:0] yadj;
	logic [20:0] era_prod;
	logic [16:0] tod_u;
	logic [16:0] off_u;
	logic signed [tsep_pkg::TOD_W-1:0] tod_c;
	logic [8:0]  doyd;

	logic [13:0] era400;
	logic [13:0] yoe_w;
	logic [8:0]  yoe;
	logic [tsep_pkg::DAYS_W-1:0] erad_u;

	logic [1:0]  cent;
	logic [tsep_pkg::DAYS_W-1:0] days_u;

	assign ld4      = !v4_q || dn_ready;
	assign ld3      = !v3_q || ld4;
	assign ld2      = !v2_q || ld3;
	assign up_ready = ld2;
	assign dn_valid = v4_q;
	assign dn_data  = res_s4;

	always_comb begin
		adj      = up_data.month <= 4'd2;
		yneg     = adj && (up_data.year == 14'd0);
		yadj     = up_data.year - {13'd0, adj};
		era_prod = {11'd0, yadj[13:4]} * {10'd0, tsep_pkg::ERA_RECIP};
		tod_u    = {12'd0, up_data.hour} * tsep_pkg::SECS_PER_HOUR
		         + {11'd0, up_data.minute} * tsep_pkg::SECS_PER_MIN
		         + {11'd0, up_data.second};
		off_u    = {12'd0, up_data.off_h} * tsep_pkg::SECS_PER_HOUR
		         + {11'd0, up_data.off_m} * tsep_pkg::SECS_PER_MIN;
		if (up_data.off_neg) begin
			tod_c = $signed({2'b00, tod_u}) + $signed({2'b00, off_u});
		end else begin
			tod_c = $signed({2'b00, tod_u}) - $signed({2'b00, off_u});
		end
		doyd = tsep_pkg::month_start(up_data.month) + {4'd0, up_data.day} - 9'd1;
	end

	always_comb begin
		era400 = {9'd0, era_s2} * 14'd400;
		yoe_w  = yadj_s2 - era400;
		yoe    = yneg_s2 ? 9'd399 : yoe_w[8:0];
		erad_u = yneg_s2 ? (~tsep_pkg::DAYS_PER_ERA + 24'd1)
		                 : {19'd0, era_s2} * tsep_pkg::DAYS_PER_ERA;
	end

	always_comb begin
		if (yoe_s3 >= 9'd300)      cent = 2'd3;
		else if (yoe_s3 >= 9'd200) cent = 2'd2;
		else if (yoe_s3 >= 9'd100) cent = 2'd1;
		else                       cent = 2'd0;
		days_u = erad_s3
		       + {15'd0, yoe_s3} * tsep_pkg::DAYS_PER_YEAR
		       + {17'd0, yoe_s3[8:2]}
		       - {22'd0, cent}
		       + {15'd0, doyd_s3}
		       - tsep_pkg::DAYS_TO_EPOCH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (ld2) v2_q <= up_valid;
			if (ld3) v3_q <= v2_q;
			if (ld4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && up_valid) begin
			ok_s2   <= up_data.ok;
			yneg_s2 <= yneg;
			yadj_s2 <= yadj;
			era_s2  <= era_prod[19:15];
			doyd_s2 <= doyd;
			tod_s2  <= tod_c;
		end
		if (ld3 && v2_q) begin
			ok_s3   <= ok_s2;
			yoe_s3  <= yoe;
			erad_s3 <= $signed(erad_u);
			doyd_s3 <= doyd_s2;
			tod_s3  <= tod_s2;
		end
		if (ld4 && v3_q) begin
			res_s4.ok   <= ok_s3;
			res_s4.days <= $signed(days_u);
			res_s4.tod  <= tod_s3;
		end
	end

endmodule

FILE: hdl/tsep_secs.sv
// ----------------------------------------------------------------------------
// tsep_secs: seconds stage and result register
// Scales the day count to seconds, adds the time of day less the zone
// offset, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module tsep_secs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  tsep_pkg::days_t                     up_data,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output logic                                ok,
	output logic signed [tsep_pkg::EPOCH_W-1:0] epoch_seconds
);

	logic                                v5_q;
	logic                                ok_s5;
	logic signed [tsep_pkg::EPOCH_W-1:0] secs_s5;
	logic signed [40:0]                  secs_w;

	assign up_ready      = !v5_q || dn_ready;
	assign dn_valid      = v5_q;
	assign ok            = ok_s5;
	assign epoch_seconds = secs_s5;

	always_comb begin
		secs_w = 41'(up_data.days) * $signed(tsep_pkg::SECS_PER_DAY) + 41'(up_data.tod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v5_q <= 1'b0;
		end else if (up_ready) begin
			v5_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			ok_s5   <= up_data.ok;
			secs_s5 <= up_data.ok ? secs_w[tsep_pkg::EPOCH_W-1:0] : '0;
		end
	end

endmodule

FILE: hdl/timestamp_text_to_epoch_seconds_unit.sv
// ----------------------------------------------------------------------------
// timestamp_text_to_epoch_seconds_unit: timestamp text to UTC epoch seconds
// Text beats come in on the text channel, at most one character per beat; the beat
// marked last closes the string, and one beat on the result channel gives
// ok and the signed UTC seconds since 1970 (zero when the text is rejected).
// Throughput is one text beat per cycle while text ready is high, also while results are in flight.
// The result of a string is registered in turn by the parser stage, three
// day-count stages and the seconds stage, starting at the edge that takes its
// last beat; the last of these stages is the result register.
// A stalled result holds in the result register; the pipeline stages behind
// it keep filling, and text ready drops only once all five result-bearing
// stages are full.
// Reset clears the parser state and all stage valid flags; no pass over
// storage is needed and the first beat may come in the cycle after release.
// ----------------------------------------------------------------------------
module timestamp_text_to_epoch_seconds_unit (
	input  logic             clk,
	input  logic             arst_n,
	tsep_text_if.sink        text,
	tsep_result_if.source    result
);

	tsep_pkg::date_t date_s1;
	tsep_pkg::days_t days_s4;
	logic            p_valid, p_ready;
	logic            d_valid, d_ready;

	tsep_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_ready  (text.ready),
		.character (text.character),
		.has_char  (text.has_char),
		.last      (text.last),
		.dn_valid  (p_valid),
		.dn_ready  (p_ready),
		.dn_data   (date_s1)
	);

	tsep_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (p_valid),
		.up_ready (p_ready),
		.up_data  (date_s1),
		.dn_valid (d_valid),
		.dn_ready (d_ready),
		.dn_data  (days_s4)
	);

	tsep_secs u_secs (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (d_valid),
		.up_ready      (d_ready),
		.up_data       (days_s4),
		.dn_valid      (result.valid),
		.dn_ready      (result.ready),
		.ok            (result.ok),
		.epoch_seconds (result.epoch_seconds)
	);

endmodule
